@@ design/lz10_pkg.sv @@
package lz10_pkg;

   localparam int WINDOW_DEPTH_DEF = 4096;
   localparam int CMD_FIFO_DEPTH = 4;

   localparam int BYTE_W = 8;
   localparam int LEN_W = 24;
   localparam int DIST_W = 12;
   localparam int COUNT_W = 5;

   localparam logic [BYTE_W-1:0] MAGIC_BYTE = 8'h10;
   localparam logic [COUNT_W-1:0] LEN_BIAS = 5'd3;

   typedef enum logic [2:0] {
      ST_DATA       = 3'd0,
      ST_DONE       = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_TRUNC_REF  = 3'd3,
      ST_TOO_FAR    = 3'd4,
      ST_SHORT      = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
      logic              run_last;
   } rsp_type;

   // One queue entry per request that produces any result.
   typedef struct packed {
      logic               has_data;
      logic               is_copy;
      logic [BYTE_W-1:0]  lit_byte;
      logic [DIST_W-1:0]  dist_code;   // distance minus one
      logic [COUNT_W-1:0] count;       // bytes to copy, already clipped
      logic               has_status;
      status_type         status;
   } cmd_type;

endpackage

@@ design/lz10_stream_decompressor.sv @@
// Channel | Direction | Handshake        | Payload
// req_    | in        | valid / stall    | in_byte, in_last
// rsp_    | out       | valid / stall    | out_byte, status, run_last
//
// The parser takes one compressed byte per cycle while its four-entry command
// queue has room; req_stall is the queue being full.
// The executor fetches a command while idle, emits each literal or status result
// from its own state, and copies each byte as a window read, then a write; each
// output waits while the result slot is stalled. A full reference is 18 bytes.
// Synchronous active-high reset clears all control state; the window is not
// cleared, and no reference can reach a byte not written in the current stream.
module lz10_stream_decompressor #(
   parameter int WINDOW_DEPTH = lz10_pkg::WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  lz10_pkg::req_type req_data,
   output logic              req_stall,
   output logic              rsp_valid,
   output lz10_pkg::rsp_type rsp_data,
   input  logic              rsp_stall
);
   import lz10_pkg::*;

   cmd_type cmd;
   cmd_type head;
   logic    cmd_push;
   logic    cmd_pop;
   logic    fifo_full;
   logic    fifo_empty;

   lz10_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .fifo_full (fifo_full),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   lz10_fifo #(
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_cmd (cmd),
      .pop    (cmd_pop),
      .head   (head),
      .full   (fifo_full),
      .empty  (fifo_empty)
   );

   lz10_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head       (head),
      .pop        (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !fifo_full)
      else $error("command pushed into full queue");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !fifo_empty)
      else $error("command popped from empty queue");

   a_status_ends_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DATA) |-> rsp_data.run_last)
      else $error("status result not marked as last of its request");

   a_idle_after_reset : assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

@@ design/lz10_front.sv @@
module lz10_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  lz10_pkg::req_type req_data,
   output logic             req_stall,
   input  logic             fifo_full,
   output logic             cmd_push,
   output lz10_pkg::cmd_type cmd
);
   import lz10_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_LEN0,
      PH_LEN1,
      PH_LEN2,
      PH_FLAG,
      PH_BODY,
      PH_REF2
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  flags_ff, flags_in;
   logic [2:0]         bit_idx_ff, bit_idx_in;
   logic [BYTE_W-1:0]  ref_first_ff, ref_first_in;
   logic [15:0]        len_lo_ff, len_lo_in;
   logic [LEN_W-1:0]   produced_ff, produced_in;
   logic [LEN_W-1:0]   remaining_ff, remaining_in;
   logic               finished_ff, finished_in;

   logic               accept;
   logic [BYTE_W-1:0]  b;
   logic               last;
   logic [LEN_W-1:0]   expected;
   logic [DIST_W-1:0]  dist_code;
   logic [COUNT_W-1:0] ref_len;
   logic               ref_fills;
   logic [COUNT_W-1:0] ref_len_eff;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.in_byte;
   assign last      = req_data.in_last;

   assign expected    = {b, len_lo_ff};
   assign dist_code   = {ref_first_ff[3:0], b};
   assign ref_len     = COUNT_W'(ref_first_ff[7:4]) + LEN_BIAS;
   assign ref_fills   = (LEN_W'(ref_len) >= remaining_ff);
   assign ref_len_eff = ref_fills ? remaining_ff[COUNT_W-1:0] : ref_len;

   always_comb begin
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      bit_idx_in   = bit_idx_ff;
      ref_first_in = ref_first_ff;
      len_lo_in    = len_lo_ff;
      produced_in  = produced_ff;
      remaining_in = remaining_ff;
      finished_in  = finished_ff;
      cmd          = '0;

      if (accept) begin
         if (!finished_ff) begin
            unique case (phase_ff)
               PH_MAGIC: begin
                  if (b != MAGIC_BYTE || last) begin
                     cmd.has_status = 1'b1;
                     cmd.status     = ST_BAD_HEADER;
                     finished_in    = 1'b1;
                  end else begin
                     phase_in = PH_LEN0;
                  end
               end
               PH_LEN0, PH_LEN1: begin
                  if (phase_ff == PH_LEN0) begin
                     len_lo_in[7:0] = b;
                  end else begin
                     len_lo_in[15:8] = b;
                  end
                  if (last) begin
                     cmd.has_status = 1'b1;
                     cmd.status     = ST_BAD_HEADER;
                     finished_in    = 1'b1;
                  end else begin
                     phase_in = (phase_ff == PH_LEN0) ? PH_LEN1 : PH_LEN2;
                  end
               end
               PH_LEN2: begin
                  remaining_in = expected;
                  produced_in  = '0;
                  phase_in     = PH_FLAG;
                  if (expected == '0) begin
                     cmd.has_status = 1'b1;
                     cmd.status     = ST_DONE;
                     finished_in    = 1'b1;
                  end else if (last) begin
                     cmd.has_status = 1'b1;
                     cmd.status     = ST_SHORT;
                     finished_in    = 1'b1;
                  end
               end
               PH_FLAG: begin
                  flags_in   = b;
                  bit_idx_in = 3'd7;
                  phase_in   = PH_BODY;
                  if (last) begin
                     cmd.has_status = 1'b1;
                     cmd.status     = ST_SHORT;
                     finished_in    = 1'b1;
                  end
               end
               PH_BODY: begin
                  if (flags_ff[bit_idx_ff]) begin
                     if (last) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_TRUNC_REF;
                        finished_in    = 1'b1;
                     end else begin
                        ref_first_in = b;
                        phase_in     = PH_REF2;
                     end
                  end else begin
                     cmd.has_data = 1'b1;
                     cmd.lit_byte = b;
                     cmd.count    = COUNT_W'(1);
                     produced_in  = produced_ff + LEN_W'(1);
                     remaining_in = remaining_ff - LEN_W'(1);
                     if (bit_idx_ff == 3'd0) begin
                        phase_in = PH_FLAG;
                     end else begin
                        bit_idx_in = bit_idx_ff - 3'd1;
                        phase_in   = PH_BODY;
                     end
                     if (remaining_ff == LEN_W'(1)) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_DONE;
                        finished_in    = 1'b1;
                     end else if (last) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_SHORT;
                        finished_in    = 1'b1;
                     end
                  end
               end
               PH_REF2: begin
                  // distance = code + 1, so too far means code >= produced
                  if (LEN_W'(dist_code) >= produced_ff) begin
                     cmd.has_status = 1'b1;
                     cmd.status     = ST_TOO_FAR;
                     finished_in    = 1'b1;
                  end else begin
                     cmd.has_data  = 1'b1;
                     cmd.is_copy   = 1'b1;
                     cmd.dist_code = dist_code;
                     cmd.count     = ref_len_eff;
                     produced_in   = produced_ff + LEN_W'(ref_len_eff);
                     remaining_in  = remaining_ff - LEN_W'(ref_len_eff);
                     if (bit_idx_ff == 3'd0) begin
                        phase_in = PH_FLAG;
                     end else begin
                        bit_idx_in = bit_idx_ff - 3'd1;
                        phase_in   = PH_BODY;
                     end
                     if (ref_fills) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_DONE;
                        finished_in    = 1'b1;
                     end else if (last) begin
                        cmd.has_status = 1'b1;
                        cmd.status     = ST_SHORT;
                        finished_in    = 1'b1;
                     end
                  end
               end
               default: begin
                  cmd.has_status = 1'b1;
                  cmd.status     = ST_BAD_HEADER;
                  finished_in    = 1'b1;
               end
            endcase
         end

         // any final byte re-arms the parser for a fresh header
         if (last) begin
            phase_in     = PH_MAGIC;
            flags_in     = '0;
            bit_idx_in   = 3'd7;
            ref_first_in = '0;
            len_lo_in    = '0;
            produced_in  = '0;
            remaining_in = '0;
            finished_in  = 1'b0;
         end
      end
   end

   assign cmd_push = accept && (cmd.has_data || cmd.has_status);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         flags_ff     <= '0;
         bit_idx_ff   <= 3'd7;
         ref_first_ff <= '0;
         len_lo_ff    <= '0;
         produced_ff  <= '0;
         remaining_ff <= '0;
         finished_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         bit_idx_ff   <= bit_idx_in;
         ref_first_ff <= ref_first_in;
         len_lo_ff    <= len_lo_in;
         produced_ff  <= produced_in;
         remaining_ff <= remaining_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

@@ design/lz10_fifo.sv @@
module lz10_fifo #(
   parameter int DEPTH = lz10_pkg::CMD_FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lz10_pkg::cmd_type wr_cmd,
   input  logic              pop,
   output lz10_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import lz10_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ design/lz10_back.sv @@
module lz10_back #(
   parameter int WINDOW_DEPTH = lz10_pkg::WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fifo_empty,
   input  lz10_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_valid,
   output lz10_pkg::rsp_type rsp_data,
   input  logic              rsp_stall
);
   import lz10_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LIT,
      S_READ,
      S_COPY,
      S_STATUS
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [BYTE_W-1:0]  hist_ff [WINDOW_DEPTH];
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               rd_en;
   logic               mem_we;
   logic [BYTE_W-1:0]  mem_wdata;
   logic               slot_free;
   logic               final_byte;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_addr    = wr_ptr_ff - AW'(cur_ff.dist_code) - AW'(1);
   assign final_byte = (left_ff == COUNT_W'(1));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      wr_ptr_in    = wr_ptr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = cur_ff.lit_byte;

      unique case (state_ff)
         S_IDLE: begin
            if (!fifo_empty) begin
               pop     = 1'b1;
               cur_in  = head;
               left_in = head.count;
               if (head.has_data) begin
                  state_in = head.is_copy ? S_READ : S_LIT;
               end else begin
                  state_in = S_STATUS;
               end
            end
         end
         S_LIT: begin
            if (slot_free) begin
               mem_we       = 1'b1;
               wr_ptr_in    = wr_ptr_ff + AW'(1);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{cur_ff.lit_byte, ST_DATA, !cur_ff.has_status};
               state_in     = cur_ff.has_status ? S_STATUS : S_IDLE;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_COPY;
         end
         S_COPY: begin
            if (slot_free) begin
               mem_we       = 1'b1;
               mem_wdata    = rd_data_ff;
               wr_ptr_in    = wr_ptr_ff + AW'(1);
               left_in      = left_ff - COUNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{rd_data_ff, ST_DATA,
                                final_byte && !cur_ff.has_status};
               if (!final_byte) begin
                  state_in = S_READ;
               end else begin
                  state_in = cur_ff.has_status ? S_STATUS : S_IDLE;
               end
            end
         end
         S_STATUS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{'0, cur_ff.status, 1'b1};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         left_ff      <= '0;
         wr_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         left_ff      <= left_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // history window: write and read never meet in the same cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_ff[wr_ptr_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= hist_ff[rd_addr];
      end
   end

endmodule

@@ bench/tb_lz10_stream_decompressor.sv @@
module tb_lz10_stream_decompressor;
   import lz10_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_LEN0,
      PH_LEN1,
      PH_LEN2,
      PH_FLAGS,
      PH_TOKEN,
      PH_REF_LO
   } phase_type;

   localparam int HISTORY_DEPTH = WINDOW_DEPTH_DEF;
   localparam int RANDOM_REQS = 90;
   localparam int DRAIN_CYCLES = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   lz10_stream_decompressor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // decoder state mirrored on the bench side
   logic [7:0]  history [HISTORY_DEPTH];
   phase_type   phase;
   logic [7:0]  flags;
   logic [2:0]  bit_idx;
   logic [7:0]  ref_hi;
   logic [23:0] want_len;
   logic [23:0] produced;
   logic        stream_over;

   rsp_type step_out[$];
   rsp_type decoded_q[$];
   req_type compressed_q[$];

   int unsigned mismatch_count = 0;
   int unsigned req_gap = 0;
   int unsigned req_count = 0;
   int unsigned stall_left = 0;
   int unsigned rsp_count = 0;

   function automatic void restart_stream();
      phase = PH_MAGIC;
      flags = '0;
      bit_idx = 3'd7;
      ref_hi = '0;
      want_len = '0;
      produced = '0;
      stream_over = 1'b0;
   endfunction

   function automatic void emit(logic [7:0] b, status_type st);
      step_out.push_back('{out_byte: b, status: st, run_last: 1'b0});
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      history[produced[11:0]] = b;
      produced = produced + 24'd1;
      emit(b, ST_DATA);
   endfunction

   function automatic void end_stream(status_type st);
      emit(8'h00, st);
      stream_over = 1'b1;
   endfunction

   function automatic void next_flag_bit();
      if (bit_idx == 3'd0) begin
         phase = PH_FLAGS;
      end else begin
         bit_idx = bit_idx - 3'd1;
         phase = PH_TOKEN;
      end
   endfunction

   function automatic void check_complete(logic last);
      if (produced >= want_len) begin
         end_stream(ST_DONE);
      end else if (last) begin
         end_stream(ST_SHORT);
      end
   endfunction

   // works out every result caused by one compressed byte
   function automatic void decode_byte(req_type r);
      logic [12:0] ref_dist;
      logic [4:0]  copy_len;
      logic [23:0] src;
      rsp_type     item;
      step_out.delete();
      if (stream_over) begin
         if (r.in_last) restart_stream();
         return;
      end
      case (phase)
         PH_MAGIC: begin
            if (r.in_byte != MAGIC_BYTE || r.in_last) end_stream(ST_BAD_HEADER);
            else phase = PH_LEN0;
         end
         PH_LEN0, PH_LEN1: begin
            if (phase == PH_LEN0) want_len[7:0] = r.in_byte;
            else want_len[15:8] = r.in_byte;
            if (r.in_last) end_stream(ST_BAD_HEADER);
            else phase = (phase == PH_LEN0) ? PH_LEN1 : PH_LEN2;
         end
         PH_LEN2: begin
            want_len[23:16] = r.in_byte;
            phase = PH_FLAGS;
            check_complete(r.in_last);
         end
         PH_FLAGS: begin
            flags = r.in_byte;
            bit_idx = 3'd7;
            phase = PH_TOKEN;
            if (r.in_last) end_stream(ST_SHORT);
         end
         PH_TOKEN: begin
            if (flags[bit_idx]) begin
               if (r.in_last) begin
                  end_stream(ST_TRUNC_REF);
               end else begin
                  ref_hi = r.in_byte;
                  phase = PH_REF_LO;
               end
            end else begin
               emit_byte(r.in_byte);
               next_flag_bit();
               check_complete(r.in_last);
            end
         end
         PH_REF_LO: begin
            ref_dist = {1'b0, ref_hi[3:0], r.in_byte} + 13'd1;
            copy_len = {1'b0, ref_hi[7:4]} + LEN_BIAS;
            if (24'(ref_dist) > produced) begin
               end_stream(ST_TOO_FAR);
            end else begin
               // copy may overlap its own output, so read after each write
               for (int i = 0; i < int'(copy_len) && produced < want_len; i++) begin
                  src = produced - 24'(ref_dist);
                  emit_byte(history[src[11:0]]);
               end
               next_flag_bit();
               check_complete(r.in_last);
            end
         end
         default: end_stream(ST_BAD_HEADER);
      endcase
      if (r.in_last) restart_stream();
      foreach (step_out[i]) begin
         item = step_out[i];
         item.run_last = (i == step_out.size() - 1);
         decoded_q.push_back(item);
      end
   endfunction

   function automatic void queue_byte(logic [7:0] b, logic last);
      compressed_q.push_back('{in_byte: b, in_last: last});
   endfunction

   // occasionally cuts the stream short on this byte
   function automatic logic queue_token(logic [7:0] b);
      logic quit;
      quit = ($urandom_range(0, 39) == 0);
      queue_byte(b, quit);
      return quit;
   endfunction

   function automatic void random_stream();
      int unsigned made;
      int unsigned code;
      int unsigned span;
      logic [7:0]  f;
      logic [23:0] len_field;
      int unsigned start;
      start = compressed_q.size();
      if ($urandom_range(0, 19) == 0) queue_byte(8'($urandom), 1'b0);
      else queue_byte(MAGIC_BYTE, 1'b0);
      case ($urandom_range(0, 9))
         0: len_field = 24'($urandom_range(0, 2));
         1: len_field = 24'($urandom);
         default: len_field = 24'($urandom_range(3, 48));
      endcase
      queue_byte(len_field[7:0], 1'b0);
      queue_byte(len_field[15:8], 1'b0);
      queue_byte(len_field[23:16], 1'b0);
      made = 0;
      while (made < len_field && compressed_q.size() - start < 60) begin
         f = 8'($urandom);
         // a reference before any data is too far, so keep it uncommon
         if (made == 0 && $urandom_range(0, 7) != 0) f[7] = 1'b0;
         if (queue_token(f)) return;
         for (int k = 7; k >= 0 && made < len_field; k--) begin
            if (f[k]) begin
               if (made == 0 || $urandom_range(0, 11) == 0)
                  code = $urandom_range(0, 4095);
               else
                  code = $urandom_range(0, (made > 4096 ? 4096 : made) - 1);
               span = $urandom_range(0, 15);
               if (queue_token({span[3:0], code[11:8]})) return;
               if (queue_token(code[7:0])) return;
               made += span + 3;
            end else begin
               if (queue_token(8'($urandom))) return;
               made++;
            end
         end
      end
      queue_byte(8'($urandom), 1'b1);
   endfunction

   function automatic int unsigned idle_length(int unsigned n);
      int unsigned r;
      if ((n / 40) % 3 == 1) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void report_mismatch(string what, rsp_type got, rsp_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: got byte %02h status %0d last %0b, want byte %02h status %0d last %0b",
                  what, got.out_byte, got.status, got.run_last,
                  want.out_byte, want.status, want.run_last);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) decode_byte(req_data);
         if (!(req_valid && req_stall)) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (compressed_q.size() != 0) begin
               req_data <= compressed_q.pop_front();
               req_valid <= 1'b1;
               req_gap = idle_length(req_count);
               req_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (decoded_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_data, '0);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.status !== want.status ||
                   rsp_data.run_last !== want.run_last)
                  report_mismatch("result mismatch", rsp_data, want);
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) stall_left = idle_length(rsp_count);
         end
      end
   end

   initial begin
      int unsigned directed_n;
      restart_stream();

      // bad magic, then bytes ignored up to the end marker
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h00, 1'b1);
      // header cut on its first byte
      queue_byte(MAGIC_BYTE, 1'b1);
      // zero length, done on the last header byte
      queue_byte(MAGIC_BYTE, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      // literal then a full-length overlapping copy clipped to five bytes
      queue_byte(MAGIC_BYTE, 1'b0);
      queue_byte(8'h06, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hF0, 1'b0);
      queue_byte(8'h00, 1'b1);
      // reference before any output: too far
      queue_byte(MAGIC_BYTE, 1'b0);
      queue_byte(8'h08, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      // maximum length, stream ends on a reference's first byte
      queue_byte(MAGIC_BYTE, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h7F, 1'b1);
      // ends short after a literal
      queue_byte(MAGIC_BYTE, 1'b0);
      queue_byte(8'h03, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7E, 1'b1);

      directed_n = compressed_q.size();
      while (compressed_q.size() < directed_n + RANDOM_REQS) random_stream();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (compressed_q.size() != 0 || req_valid || decoded_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
design/lz10_pkg.sv
design/lz10_front.sv
design/lz10_fifo.sv
design/lz10_back.sv
design/lz10_stream_decompressor.sv
bench/tb_lz10_stream_decompressor.sv
